[rtl/rvid_pkg.sv]
// Shared types, opcode codes and decode result layout for the RV32I decoder.
`default_nettype none

package rvid_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned REG_W  = 5;
  localparam int unsigned FMT_W  = 3;
  localparam int unsigned OP_W   = 6;

  typedef enum logic [6:0] {
    OPC_LUI    = 7'b0110111,
    OPC_AUIPC  = 7'b0010111,
    OPC_JAL    = 7'b1101111,
    OPC_JALR   = 7'b1100111,
    OPC_BRANCH = 7'b1100011,
    OPC_LOAD   = 7'b0000011,
    OPC_STORE  = 7'b0100011,
    OPC_OP_IMM = 7'b0010011,
    OPC_OP     = 7'b0110011
  } opcode_t;

  typedef enum logic [FMT_W-1:0] {
    FMT_R = 3'd0,
    FMT_I = 3'd1,
    FMT_S = 3'd2,
    FMT_B = 3'd3,
    FMT_U = 3'd4,
    FMT_J = 3'd5
  } fmt_t;

  typedef enum logic [OP_W-1:0] {
    OP_LUI   = 6'd0,  OP_AUIPC = 6'd1,  OP_JAL   = 6'd2,  OP_JALR  = 6'd3,
    OP_BEQ   = 6'd4,  OP_BNE   = 6'd5,  OP_BLT   = 6'd6,  OP_BGE   = 6'd7,
    OP_BLTU  = 6'd8,  OP_BGEU  = 6'd9,  OP_LB    = 6'd10, OP_LH    = 6'd11,
    OP_LW    = 6'd12, OP_LBU   = 6'd13, OP_LHU   = 6'd14, OP_SB    = 6'd15,
    OP_SH    = 6'd16, OP_SW    = 6'd17, OP_ADDI  = 6'd18, OP_SLTI  = 6'd19,
    OP_SLTIU = 6'd20, OP_XORI  = 6'd21, OP_ORI   = 6'd22, OP_ANDI  = 6'd23,
    OP_SLLI  = 6'd24, OP_SRLI  = 6'd25, OP_SRAI  = 6'd26, OP_ADD   = 6'd27,
    OP_SUB   = 6'd28, OP_SLL   = 6'd29, OP_SLT   = 6'd30, OP_SLTU  = 6'd31,
    OP_XOR   = 6'd32, OP_SRL   = 6'd33, OP_SRA   = 6'd34, OP_OR    = 6'd35,
    OP_AND   = 6'd36
  } op_t;

  typedef struct packed {
    logic                     legal;
    fmt_t                     fmt;
    op_t                      op;
    logic [REG_W-1:0]         rd;
    logic [REG_W-1:0]         rs1;
    logic [REG_W-1:0]         rs2;
    logic signed [WORD_W-1:0] imm;
  } dec_res_t;

endpackage

`default_nettype wire

[rtl/rvid_if.sv]
// Valid/ready channel interfaces for instruction words and decode results.
`default_nettype none

interface rvid_in_if;
  import rvid_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] instr_word;

  modport source (output valid, output instr_word, input ready);
  modport sink   (input valid, input instr_word, output ready);
endinterface

interface rvid_out_if;
  import rvid_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     legal;
  logic [FMT_W-1:0]         format;
  logic [OP_W-1:0]          operation;
  logic [REG_W-1:0]         dest_reg;
  logic [REG_W-1:0]         src_reg_a;
  logic [REG_W-1:0]         src_reg_b;
  logic signed [WORD_W-1:0] immediate;

  modport source (output valid, output legal, output format, output operation,
                  output dest_reg, output src_reg_a, output src_reg_b,
                  output immediate, input ready);
  modport sink   (input valid, input legal, input format, input operation,
                  input dest_reg, input src_reg_a, input src_reg_b,
                  input immediate, output ready);
endinterface

`default_nettype wire

[rtl/rvid_decode.sv]
// Combinational field extraction, operation lookup and immediate assembly.
`default_nettype none

module rvid_decode (
  input  logic [rvid_pkg::WORD_W-1:0] word,
  output rvid_pkg::dec_res_t          res
);
  import rvid_pkg::*;

  logic [2:0]         f3;
  logic               b30;
  logic [WORD_W-1:0]  imm_i;
  logic [WORD_W-1:0]  imm_s;
  logic [WORD_W-1:0]  imm_b;
  logic [WORD_W-1:0]  imm_u;
  logic [WORD_W-1:0]  imm_j;
  dec_res_t           dec;

  assign f3  = word[14:12];
  assign b30 = word[30];

  assign imm_i = {{20{word[31]}}, word[31:20]};
  assign imm_s = {{20{word[31]}}, word[31:25], word[11:7]};
  assign imm_b = {{19{word[31]}}, word[31], word[7], word[30:25], word[11:8], 1'b0};
  assign imm_u = {word[31:12], 12'b0};
  assign imm_j = {{11{word[31]}}, word[31], word[19:12], word[20], word[30:21], 1'b0};

  always_comb begin
    dec       = '0;
    dec.legal = 1'b1;
    unique case (word[6:0])
      OPC_LUI, OPC_AUIPC: begin
        dec.fmt = FMT_U;
        dec.op  = (word[6:0] == OPC_LUI) ? OP_LUI : OP_AUIPC;
        dec.rd  = word[11:7];
        dec.imm = imm_u;
      end
      OPC_JAL: begin
        dec.fmt = FMT_J;
        dec.op  = OP_JAL;
        dec.rd  = word[11:7];
        dec.imm = imm_j;
      end
      OPC_JALR: begin
        dec.legal = (f3 == 3'd0);
        dec.fmt   = FMT_I;
        dec.op    = OP_JALR;
        dec.rd    = word[11:7];
        dec.rs1   = word[19:15];
        dec.imm   = imm_i;
      end
      OPC_BRANCH: begin
        dec.fmt = FMT_B;
        dec.rs1 = word[19:15];
        dec.rs2 = word[24:20];
        dec.imm = imm_b;
        unique case (f3)
          3'd0:    dec.op = OP_BEQ;
          3'd1:    dec.op = OP_BNE;
          3'd4:    dec.op = OP_BLT;
          3'd5:    dec.op = OP_BGE;
          3'd6:    dec.op = OP_BLTU;
          3'd7:    dec.op = OP_BGEU;
          default: dec.legal = 1'b0;
        endcase
      end
      OPC_LOAD: begin
        dec.fmt = FMT_I;
        dec.rd  = word[11:7];
        dec.rs1 = word[19:15];
        dec.imm = imm_i;
        unique case (f3)
          3'd0:    dec.op = OP_LB;
          3'd1:    dec.op = OP_LH;
          3'd2:    dec.op = OP_LW;
          3'd4:    dec.op = OP_LBU;
          3'd5:    dec.op = OP_LHU;
          default: dec.legal = 1'b0;
        endcase
      end
      OPC_STORE: begin
        dec.fmt = FMT_S;
        dec.rs1 = word[19:15];
        dec.rs2 = word[24:20];
        dec.imm = imm_s;
        unique case (f3)
          3'd0:    dec.op = OP_SB;
          3'd1:    dec.op = OP_SH;
          3'd2:    dec.op = OP_SW;
          default: dec.legal = 1'b0;
        endcase
      end
      OPC_OP_IMM: begin
        dec.fmt = FMT_I;
        dec.rd  = word[11:7];
        dec.rs1 = word[19:15];
        dec.imm = imm_i;
        unique case (f3)
          3'd0: dec.op = OP_ADDI;
          3'd1: dec.op = OP_SLLI;
          3'd2: dec.op = OP_SLTI;
          3'd3: dec.op = OP_SLTIU;
          3'd4: dec.op = OP_XORI;
          3'd5: dec.op = b30 ? OP_SRAI : OP_SRLI;
          3'd6: dec.op = OP_ORI;
          3'd7: dec.op = OP_ANDI;
        endcase
      end
      OPC_OP: begin
        dec.fmt = FMT_R;
        dec.rd  = word[11:7];
        dec.rs1 = word[19:15];
        dec.rs2 = word[24:20];
        unique case (f3)
          3'd0: dec.op = b30 ? OP_SUB : OP_ADD;
          3'd1: dec.op = OP_SLL;
          3'd2: dec.op = OP_SLT;
          3'd3: dec.op = OP_SLTU;
          3'd4: dec.op = OP_XOR;
          3'd5: dec.op = b30 ? OP_SRA : OP_SRL;
          3'd6: dec.op = OP_OR;
          3'd7: dec.op = OP_AND;
        endcase
      end
      default: dec.legal = 1'b0;
    endcase

    // An illegal word reports every field as zero.
    if (dec.legal) begin
      res = dec;
    end else begin
      res = '0;
    end
  end

endmodule

`default_nettype wire

[rtl/rv32i_instruction_decoder.sv]
// Top level of the RV32I decoder: input register, decode logic, result register.
//
//  Channel  Direction  Payload                                        Handshake
//  in_chan  input      instr_word[31:0]                               valid/ready
//  out_chan output     legal, format, operation, dest_reg,            valid/ready
//                      src_reg_a, src_reg_b, immediate[31:0]
//
// One instruction is accepted per cycle while input ready is high; the word is
// held in the input register, and its decoded result is then registered in the
// result register, from which it is offered on the output channel.
// Reset empties both stages; no decode state survives between transactions.
// When the output stalls, the result register holds and the input register
// still takes one more word, so input ready drops only when both are full.
`default_nettype none

module rv32i_instruction_decoder (
  input  logic              clk,
  input  logic              rst_n,
  rvid_in_if.sink           in_chan,
  rvid_out_if.source        out_chan
);
  import rvid_pkg::*;

  logic              s1_valid_r;
  logic              s1_valid_nxt;
  logic [WORD_W-1:0] s1_word_r;
  logic              s2_valid_r;
  logic              s2_valid_nxt;
  dec_res_t          s2_res_r;
  dec_res_t          dec_res;
  logic              s2_load;
  logic              s1_load;

  rvid_decode u_decode (
    .word (s1_word_r),
    .res  (dec_res)
  );

  // The result stage can take a new word when it is empty or being drained.
  assign s2_load = s1_valid_r && (!s2_valid_r || out_chan.ready);
  assign s1_load = in_chan.valid && in_chan.ready;

  assign in_chan.ready = !s1_valid_r || !s2_valid_r || out_chan.ready;

  always_comb begin
    s1_valid_nxt = s1_load || (s1_valid_r && !s2_load);
    s2_valid_nxt = s2_load || (s2_valid_r && !out_chan.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_word_r <= in_chan.instr_word;
    end
    if (s2_load) begin
      s2_res_r <= dec_res;
    end
  end

  assign out_chan.valid     = s2_valid_r;
  assign out_chan.legal     = s2_res_r.legal;
  assign out_chan.format    = s2_res_r.fmt;
  assign out_chan.operation = s2_res_r.op;
  assign out_chan.dest_reg  = s2_res_r.rd;
  assign out_chan.src_reg_a = s2_res_r.rs1;
  assign out_chan.src_reg_b = s2_res_r.rs2;
  assign out_chan.immediate = s2_res_r.imm;

endmodule

`default_nettype wire

[rtl/rvid_checker.sv]
// Port-level assertions for the RV32I decoder and the bind that attaches them.
`default_nettype none

module rvid_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           out_legal,
  input logic [rvid_pkg::FMT_W-1:0]     out_format,
  input logic [rvid_pkg::OP_W-1:0]      out_operation,
  input logic [rvid_pkg::REG_W-1:0]     out_dest_reg,
  input logic [rvid_pkg::REG_W-1:0]     out_src_reg_a,
  input logic [rvid_pkg::REG_W-1:0]     out_src_reg_b,
  input logic [rvid_pkg::WORD_W-1:0]    out_immediate
);
  import rvid_pkg::*;

  // A stalled result keeps its valid, its operation, its immediate and its legal flag.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_operation) &&
      $stable(out_immediate) && $stable(out_legal))
    else $error("result changed while stalled");

  // A draining output never blocks the input side.
  a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input not ready while output drains");

  // A transaction followed by output ready is followed by a valid result.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready ##1 out_ready |=> out_valid)
    else $error("result missing two cycles after transaction");

  // An illegal word reports all-zero fields.
  a_illegal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_legal |-> out_format == 3'd0 && out_operation == 6'd0 &&
      out_dest_reg == 5'd0 && out_src_reg_a == 5'd0 && out_src_reg_b == 5'd0 &&
      out_immediate == 32'd0)
    else $error("illegal result with nonzero fields");

  // R format has no immediate, S and B formats have no destination.
  a_format_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_format != FMT_R || out_immediate == 32'd0) &&
      ((out_format != FMT_S && out_format != FMT_B) || out_dest_reg == 5'd0))
    else $error("unused field nonzero for format");

endmodule

bind rv32i_instruction_decoder rvid_checker u_rvid_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_legal     (out_chan.legal),
  .out_format    (out_chan.format),
  .out_operation (out_chan.operation),
  .out_dest_reg  (out_chan.dest_reg),
  .out_src_reg_a (out_chan.src_reg_a),
  .out_src_reg_b (out_chan.src_reg_b),
  .out_immediate (out_chan.immediate)
);

`default_nettype wire
